>>> src/pli_pkg.sv
// Shared widths, codes and the adder request type for the interpolator.
package pli_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int FREQ_W     = 32;
  localparam int AMP_W      = 32;
  localparam int IDX_W      = 6;
  localparam int CFG_W      = 7;
  localparam int ENTRY_W    = FREQ_W + AMP_W;
  localparam int IN_DATA_W  = 72;   // 6 + 32 + 32 = 70, padded to bytes
  localparam int OUT_DATA_W = 104;  // 32 + 1 + 32 + 32 + 1 = 98, padded to bytes
  localparam int ALU_W      = 34;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

>>> src/pli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/pli_alu.sv
// Shared 34-bit add/subtract unit used for every arithmetic step of a query.
module pli_alu (
  input  pli_pkg::alu_req_t           req,
  output logic [pli_pkg::ALU_W-1:0]   sum
);
  import pli_pkg::*;

  logic [ALU_W-1:0] b_eff;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign sum   = req.a + b_eff + ALU_W'(req.sub);

endmodule

>>> src/piecewise_linear_interpolator.sv
// Piecewise linear interpolator: breakpoint table, search sequencer and serial mul/div.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | tuser: operation; tdata: index, freq, amp
//  m_*     | out | m_tvalid / m_tready  | tdata: amplitude, in_range, fmin, fmax, sat
//  cfg_*   | in  | cfg_valid / cfg_ready| cfg_data: points_in_use
//
// A load writes its entry as it is accepted. A query runs, as far as it needs, through two
// reads for the end points, a linear scan for an exact hit, a second scan for the containing
// segment, four setup steps, 32 multiply and 32 divide steps and a final add, all through the
// one shared adder and one table read port. Reset clears the sequencer, m_tvalid and
// points_in_use; the table has no reset and no clearing pass. Loads are taken while a
// result waits on m_*; a query holds in its last state until the output register is free.
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave transaction channel
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic                            s_tuser,   // [0] operation
  // [5:0] point_index, [37:6] frequency, [69:38] amplitude_in, [71:70] zero
  input  logic [pli_pkg::IN_DATA_W-1:0]   s_tdata,
  // master transaction channel
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] amplitude, [32] in_range, [64:33] min_frequency, [96:65] max_frequency,
  // [97] saturated, [103:98] zero
  output logic [pli_pkg::OUT_DATA_W-1:0]  m_tdata,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pli_pkg::CFG_W-1:0]       cfg_data
);
  import pli_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int STEP_W = $clog2(FREQ_W);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_RD_MIN = 13'b0000000000010,
    S_RD_MAX = 13'b0000000000100,
    S_EXACT  = 13'b0000000001000,
    S_SEG    = 13'b0000000010000,
    S_DY     = 13'b0000000100000,
    S_MAG    = 13'b0000001000000,
    S_OFF    = 13'b0000010000000,
    S_DX     = 13'b0000100000000,
    S_MUL    = 13'b0001000000000,
    S_DIV    = 13'b0010000000000,
    S_SUM    = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state;

  // input field views
  logic [IDX_W-1:0]  in_idx;
  logic [FREQ_W-1:0] in_freq;
  logic [AMP_W-1:0]  in_amp;

  assign in_idx  = s_tdata[IDX_W-1:0];
  assign in_freq = s_tdata[IDX_W +: FREQ_W];
  assign in_amp  = s_tdata[IDX_W+FREQ_W +: AMP_W];

  // configuration
  logic [CFG_W-1:0] points_in_use;
  logic [CNT_W-1:0] n_active;
  logic [CNT_W-1:0] last_idx;

  assign cfg_ready = 1'b1;
  assign n_active  = (32'(points_in_use) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                       : CNT_W'(points_in_use);
  assign last_idx  = n_active - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      points_in_use <= cfg_data;
    end
  end

  // breakpoint table: {amplitude, frequency}
  logic               s_xfer;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [FREQ_W-1:0]  rd_freq;
  logic [AMP_W-1:0]   rd_amp;

  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign ram_we   = s_xfer && (s_tuser == OP_LOAD) && (32'(in_idx) < MAX_POINTS);
  assign rd_freq  = ram_rdata[FREQ_W-1:0];
  assign rd_amp   = ram_rdata[FREQ_W +: AMP_W];

  pli_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_idx)),
    .wdata ({in_amp, in_freq}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // query working registers
  logic [FREQ_W-1:0]   qf;
  logic [FREQ_W-1:0]   fmin;
  logic [FREQ_W-1:0]   fmax;
  logic [CNT_W-1:0]    ptr;
  logic [FREQ_W-1:0]   prev_freq;
  logic [AMP_W-1:0]    prev_amp;
  logic                seg_found;
  logic [FREQ_W-1:0]   f0;
  logic [FREQ_W-1:0]   f1;
  logic [AMP_W-1:0]    a0;
  logic [AMP_W-1:0]    a1;
  logic [AMP_W:0]      dy;
  logic [AMP_W-1:0]    mag;
  logic [FREQ_W-1:0]   dx;
  logic [2*FREQ_W-1:0] prod;   // multiply accumulator, then remainder / quotient
  logic [STEP_W-1:0]   iter;
  logic [AMP_W-1:0]    res_amp;
  logic                res_inr;
  logic                res_sat;

  // shared adder
  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_sum;

  pli_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  logic seg_hit;
  logic div_neg;
  logic last_step;
  logic out_free;

  assign seg_hit   = (ptr != CNT_W'(1)) && (prev_freq < qf) && (qf < rd_freq);
  assign div_neg   = alu_sum[ALU_W-1];
  assign last_step = (iter == STEP_W'(FREQ_W - 1));
  assign out_free  = !m_tvalid || m_tready;

  // read address and adder operands per state
  always_comb begin
    ram_raddr = '0;
    alu_req   = '0;
    unique case (state)
      S_RD_MIN: ram_raddr = last_idx[AW-1:0];
      S_EXACT:  ram_raddr = (ptr == n_active) ? '0 : ptr[AW-1:0];
      S_SEG:    ram_raddr = ptr[AW-1:0];
      S_DY: begin
        alu_req.a   = {{2{a1[AMP_W-1]}}, a1};
        alu_req.b   = {{2{a0[AMP_W-1]}}, a0};
        alu_req.sub = 1'b1;
      end
      S_MAG: begin
        alu_req.b   = {dy[AMP_W], dy};
        alu_req.sub = 1'b1;
      end
      S_OFF: begin
        alu_req.a   = {2'b00, qf};
        alu_req.b   = {2'b00, f0};
        alu_req.sub = 1'b1;
      end
      S_DX: begin
        alu_req.a   = {2'b00, f1};
        alu_req.b   = {2'b00, f0};
        alu_req.sub = 1'b1;
      end
      S_MUL: begin
        alu_req.a = {2'b00, prod[2*FREQ_W-1:FREQ_W]};
        alu_req.b = prod[0] ? {2'b00, mag} : '0;
      end
      S_DIV: begin
        // shift the next dividend bit into the remainder and trial-subtract
        alu_req.a   = {1'b0, prod[2*FREQ_W-1:FREQ_W], prod[FREQ_W-1]};
        alu_req.b   = {2'b00, dx};
        alu_req.sub = 1'b1;
      end
      S_SUM: begin
        alu_req.a   = {{2{a0[AMP_W-1]}}, a0};
        alu_req.b   = {2'b00, prod[FREQ_W-1:0]};
        alu_req.sub = dy[AMP_W];
      end
      default: ram_raddr = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_xfer && (s_tuser == OP_QUERY)) begin
            state <= (n_active == '0) ? S_OUT : S_RD_MIN;
          end
        end
        S_RD_MIN: state <= S_RD_MAX;
        S_RD_MAX: state <= (qf >= fmin && qf <= rd_freq) ? S_EXACT : S_OUT;
        S_EXACT: begin
          if (rd_freq == qf) begin
            state <= S_OUT;
          end else if (ptr == n_active) begin
            state <= S_SEG;
          end
        end
        S_SEG: begin
          if (ptr == n_active) begin
            state <= (seg_hit || seg_found) ? S_DY : S_OUT;
          end
        end
        S_DY:  state <= S_MAG;
        S_MAG: state <= S_OFF;
        S_OFF: state <= S_DX;
        S_DX:  state <= S_MUL;
        S_MUL: if (last_step) state <= S_DIV;
        S_DIV: if (last_step) state <= S_SUM;
        S_SUM: state <= S_OUT;
        S_OUT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_xfer) begin
          qf        <= in_freq;
          fmin      <= '0;
          fmax      <= '0;
          res_amp   <= '0;
          res_inr   <= 1'b0;
          res_sat   <= 1'b0;
          seg_found <= 1'b0;
        end
      end
      S_RD_MIN: fmin <= rd_freq;
      S_RD_MAX: begin
        fmax <= rd_freq;
        ptr  <= CNT_W'(1);
        if (qf >= fmin && qf <= rd_freq) begin
          res_inr <= 1'b1;
        end
      end
      S_EXACT: begin
        if (rd_freq == qf) begin
          res_amp <= rd_amp;
        end else if (ptr == n_active) begin
          ptr <= CNT_W'(1);
        end else begin
          ptr <= ptr + CNT_W'(1);
        end
      end
      S_SEG: begin
        prev_freq <= rd_freq;
        prev_amp  <= rd_amp;
        ptr       <= ptr + CNT_W'(1);
        // the highest containing segment wins
        if (seg_hit) begin
          seg_found <= 1'b1;
          f0        <= prev_freq;
          a0        <= prev_amp;
          f1        <= rd_freq;
          a1        <= rd_amp;
        end
      end
      S_DY:  dy  <= alu_sum[AMP_W:0];
      S_MAG: mag <= dy[AMP_W] ? alu_sum[AMP_W-1:0] : dy[AMP_W-1:0];
      S_OFF: prod <= {{FREQ_W{1'b0}}, alu_sum[FREQ_W-1:0]};
      S_DX: begin
        dx   <= alu_sum[FREQ_W-1:0];
        iter <= '0;
      end
      S_MUL: begin
        prod <= {alu_sum[FREQ_W:0], prod[FREQ_W-1:1]};
        iter <= iter + STEP_W'(1);
      end
      S_DIV: begin
        // remainder in the upper half, quotient bits shift in at the bottom
        prod <= {(div_neg ? {prod[2*FREQ_W-2:FREQ_W], prod[FREQ_W-1]}
                          : alu_sum[FREQ_W-1:0]),
                 prod[FREQ_W-2:0], !div_neg};
        iter <= iter + STEP_W'(1);
      end
      S_SUM: begin
        if (alu_sum[ALU_W-1:AMP_W-1] != '0 && alu_sum[ALU_W-1:AMP_W-1] != '1) begin
          res_sat <= 1'b1;
          res_amp <= alu_sum[ALU_W-1] ? {1'b1, {(AMP_W-1){1'b0}}}
                                      : {1'b0, {(AMP_W-1){1'b1}}};
        end else begin
          res_amp <= alu_sum[AMP_W-1:0];
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {{(OUT_DATA_W - 2*FREQ_W - AMP_W - 2){1'b0}},
                  res_sat, fmax, fmin, res_inr, res_amp};
    end
  end

`ifndef SYNTHESIS
  a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (prod[2*FREQ_W-1:FREQ_W] < dx))
    else $error("division remainder not below divisor");

  a_mul_nonzero_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (dx != '0))
    else $error("segment span is zero during interpolation");

  a_sat_needs_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2*FREQ_W+AMP_W+1]) |-> m_tdata[AMP_W])
    else $error("saturated result reported outside the table span");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_QUERY) |=> !s_tready)
    else $error("ready held high after a query transaction");
`endif

endmodule
